// ===== hw/rtl/mlfr_pkg.sv =====
// Shared types and constants for the magic-length frame receiver.
// Used by every module of the block; depends on nothing.
`default_nettype none

package mlfr_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned LEN_W    = 16;
	localparam int unsigned MAGIC_W  = 32;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned APB_DW   = 32;
	localparam int unsigned APB_AW   = 3;

	localparam logic [MAGIC_W-1:0] MAGIC_RESET   = '0;
	localparam logic [LEN_W-1:0]   MAX_PAY_RESET = '1;

	typedef enum logic [2:0] {
		PH_MAGIC0  = 3'd0,
		PH_MAGIC1  = 3'd1,
		PH_MAGIC2  = 3'd2,
		PH_MAGIC3  = 3'd3,
		PH_LEN_LO  = 3'd4,
		PH_LEN_HI  = 3'd5,
		PH_PAYLOAD = 3'd6
	} phase_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_NONE    = 2'd0,
		ST_DONE    = 2'd1,
		ST_LEN_ERR = 2'd2
	} status_t;

	typedef enum logic {
		REG_MAGIC       = 1'b0,
		REG_MAX_PAYLOAD = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [MAGIC_W-1:0] magic_word;
		logic [LEN_W-1:0]   max_payload;
	} cfg_t;

	typedef struct packed {
		status_t            status;
		logic               data_valid;
		logic [BYTE_W-1:0]  data_byte;
		logic [LEN_W-1:0]   data_index;
	} res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/magic_length_frame_receiver_core.sv =====
// Top level of the magic-length frame receiver: APB registers, frame parser
// and result register. Depends on mlfr_pkg, mlfr_cfg_regs, mlfr_parser, mlfr_out_stage.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------------
//   input    | in_valid / in_ready  | rx_byte[7:0], restart
//   output   | out_valid/out_ready  | status[1:0], data_valid, data_byte[7:0],
//            |                      | data_index[15:0]
//   config   | psel/penable/pwrite  | paddr[2:0], pwdata[31:0], prdata[31:0]
//
// The parser state advances at the accepting edge and the result lands in
// the result register at that same edge, so a result is offered in the cycle
// after its input beat is accepted.
// Sustained rate is one beat per cycle; in_ready drops only while a result is
// held and out_ready is low, so a stall on the output side holds the input.
// arst_n clears the parse phase, length and count, the output valid flag and
// the registers to their defaults (magic word 0, maximum payload 65535).
`default_nettype none

module magic_length_frame_receiver_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// input beats
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [mlfr_pkg::BYTE_W-1:0]        rx_byte,
	input  wire logic                               restart,
	// result beats
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [mlfr_pkg::STATUS_W-1:0]           status,
	output logic                                    data_valid,
	output logic [mlfr_pkg::BYTE_W-1:0]             data_byte,
	output logic [mlfr_pkg::LEN_W-1:0]              data_index,
	// configuration
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [mlfr_pkg::APB_AW-1:0]        paddr,
	input  wire logic [mlfr_pkg::APB_DW-1:0]        pwdata,
	output logic      [mlfr_pkg::APB_DW-1:0]        prdata,
	output logic                                    pready
);

	mlfr_pkg::cfg_t cfg;
	mlfr_pkg::res_t res_next;
	mlfr_pkg::res_t res_held;
	logic           in_accept;
	logic           room;

	// advance the parser only on an accepted beat
	assign in_ready  = room;
	assign in_accept = in_valid && room;

	mlfr_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mlfr_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (in_accept),
		.rx_byte (rx_byte),
		.restart (restart),
		.cfg     (cfg),
		.res     (res_next)
	);

	mlfr_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (in_accept),
		.res       (res_next),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.room      (room),
		.res_out   (res_held)
	);

	// unpack the held beat onto the result ports
	assign status     = res_held.status;
	assign data_valid = res_held.data_valid;
	assign data_byte  = res_held.data_byte;
	assign data_index = res_held.data_index;

endmodule

`default_nettype wire

// ===== hw/rtl/mlfr_cfg_regs.sv =====
// APB register file: magic word and maximum payload length.
// Depends on mlfr_pkg.
`default_nettype none

module mlfr_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [mlfr_pkg::APB_AW-1:0]   paddr,
	input  wire logic [mlfr_pkg::APB_DW-1:0]   pwdata,
	output logic      [mlfr_pkg::APB_DW-1:0]   prdata,
	output logic                               pready,
	output mlfr_pkg::cfg_t                     cfg
);

	mlfr_pkg::cfg_t    cfg_q;
	mlfr_pkg::reg_idx_t reg_sel;
	logic              wr_en;

	assign reg_sel = mlfr_pkg::reg_idx_t'(paddr[2]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.magic_word  <= mlfr_pkg::MAGIC_RESET;
			cfg_q.max_payload <= mlfr_pkg::MAX_PAY_RESET;
		end else if (wr_en) begin
			case (reg_sel)
				mlfr_pkg::REG_MAGIC: begin
					cfg_q.magic_word <= pwdata[mlfr_pkg::MAGIC_W-1:0];
				end
				mlfr_pkg::REG_MAX_PAYLOAD: begin
					cfg_q.max_payload <= pwdata[mlfr_pkg::LEN_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			mlfr_pkg::REG_MAGIC: begin
				prdata = cfg_q.magic_word;
			end
			mlfr_pkg::REG_MAX_PAYLOAD: begin
				prdata = {{(mlfr_pkg::APB_DW-mlfr_pkg::LEN_W){1'b0}}, cfg_q.max_payload};
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/mlfr_parser.sv =====
// Frame parser: phase register, length and count registers, and the
// per-byte result logic. Depends on mlfr_pkg.
`default_nettype none

module mlfr_parser (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         accept,
	input  wire logic [mlfr_pkg::BYTE_W-1:0]  rx_byte,
	input  wire logic                         restart,
	input  wire mlfr_pkg::cfg_t               cfg,
	output mlfr_pkg::res_t                    res
);

	mlfr_pkg::phase_t            phase_q, phase_d;
	logic [mlfr_pkg::LEN_W-1:0]  exp_len_q, exp_len_d;
	logic [mlfr_pkg::LEN_W-1:0]  rcv_cnt_q, rcv_cnt_d;
	logic [mlfr_pkg::LEN_W-1:0]  len_full;
	logic [mlfr_pkg::LEN_W-1:0]  cnt_inc;
	logic [mlfr_pkg::BYTE_W-1:0] want;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= mlfr_pkg::PH_MAGIC0;
			exp_len_q <= '0;
			rcv_cnt_q <= '0;
		end else if (accept) begin
			phase_q   <= phase_d;
			exp_len_q <= exp_len_d;
			rcv_cnt_q <= rcv_cnt_d;
		end
	end

	assign want     = cfg.magic_word[phase_q[1:0]*mlfr_pkg::BYTE_W +: mlfr_pkg::BYTE_W];
	assign len_full = {rx_byte, exp_len_q[mlfr_pkg::BYTE_W-1:0]};
	assign cnt_inc  = rcv_cnt_q + 1'b1;

	always_comb begin
		phase_d        = phase_q;
		exp_len_d      = exp_len_q;
		rcv_cnt_d      = rcv_cnt_q;
		res.status     = mlfr_pkg::ST_NONE;
		res.data_valid = 1'b0;
		res.data_byte  = '0;
		res.data_index = '0;
		if (restart) begin
			phase_d   = mlfr_pkg::PH_MAGIC0;
			exp_len_d = '0;
			rcv_cnt_d = '0;
		end else begin
			case (phase_q)
				mlfr_pkg::PH_MAGIC0, mlfr_pkg::PH_MAGIC1,
				mlfr_pkg::PH_MAGIC2, mlfr_pkg::PH_MAGIC3: begin
					// drop back to hunting on mismatch; failing byte is not rechecked
					phase_d = (rx_byte == want) ? mlfr_pkg::phase_t'(phase_q + 3'd1)
					                            : mlfr_pkg::PH_MAGIC0;
				end
				mlfr_pkg::PH_LEN_LO: begin
					exp_len_d = {{(mlfr_pkg::LEN_W-mlfr_pkg::BYTE_W){1'b0}}, rx_byte};
					phase_d   = mlfr_pkg::PH_LEN_HI;
				end
				mlfr_pkg::PH_LEN_HI: begin
					exp_len_d = len_full;
					if (len_full == '0 || len_full > cfg.max_payload) begin
						phase_d    = mlfr_pkg::PH_MAGIC0;
						res.status = mlfr_pkg::ST_LEN_ERR;
					end else begin
						rcv_cnt_d = '0;
						phase_d   = mlfr_pkg::PH_PAYLOAD;
					end
				end
				mlfr_pkg::PH_PAYLOAD: begin
					res.data_valid = 1'b1;
					res.data_byte  = rx_byte;
					res.data_index = rcv_cnt_q;
					rcv_cnt_d      = cnt_inc;
					if (cnt_inc == exp_len_q) begin
						phase_d    = mlfr_pkg::PH_MAGIC0;
						res.status = mlfr_pkg::ST_DONE;
					end
				end
				default: begin
					// unreachable phase code: drop the byte, flag a length error and hunt again
					phase_d    = mlfr_pkg::PH_MAGIC0;
					res.status = mlfr_pkg::ST_LEN_ERR;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/mlfr_out_stage.sv =====
// Result register with valid/ready handshake toward the consumer.
// Depends on mlfr_pkg.
`default_nettype none

module mlfr_out_stage (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            load,
	input  wire mlfr_pkg::res_t  res,
	input  wire logic            out_ready,
	output logic                 out_valid,
	output logic                 room,
	output mlfr_pkg::res_t       res_out
);

	logic           out_valid_q;
	mlfr_pkg::res_t res_s1;

	// room whenever the held beat leaves in this cycle or nothing is held
	assign room      = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign res_out   = res_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (room) begin
			out_valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s1 <= res;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/mlfr_checker.sv =====
// Port-level checks for the magic-length frame receiver, bound to the top.
// Depends on mlfr_pkg and magic_length_frame_receiver_core.
`default_nettype none

module mlfr_checker (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	input  wire logic                               in_ready,
	input  wire logic                               out_valid,
	input  wire logic                               out_ready,
	input  wire logic [mlfr_pkg::STATUS_W-1:0]      status,
	input  wire logic                               data_valid,
	input  wire logic [mlfr_pkg::BYTE_W-1:0]        data_byte,
	input  wire logic [mlfr_pkg::LEN_W-1:0]         data_index
);

	// a stalled result beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat withdrawn while stalled");

	// every accepted input beat yields a result beat in the next cycle
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted beat produced no result");

	// a non-payload result carries zero byte and index
	a_zero_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !data_valid |-> data_byte == '0 && data_index == '0)
		else $error("non-payload result with nonzero data");

	// a length error never comes with a payload byte
	a_err_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == mlfr_pkg::ST_LEN_ERR |-> !data_valid)
		else $error("length error flagged on a payload byte");

	// frame complete only on a payload byte, and no unused status code
	a_done_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == mlfr_pkg::ST_NONE || status == mlfr_pkg::ST_LEN_ERR
		               || (status == mlfr_pkg::ST_DONE && data_valid)))
		else $error("bad status on result beat");

endmodule

bind magic_length_frame_receiver_core mlfr_checker u_mlfr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.status     (status),
	.data_valid (data_valid),
	.data_byte  (data_byte),
	.data_index (data_index)
);

`default_nettype wire
